[rtl/ssl_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssl_pkg: servo slew limiter shared types and constants
// Field types of the command and result channels, mode and register codes,
// and the fixed-point constants of the slew arithmetic (1/64 degree units).
// ----------------------------------------------------------------------------
package ssl_pkg;

  typedef logic        [2:0]  mode_t;
  typedef logic signed [15:0] angle_t;
  typedef logic        [13:0] pos_t;
  typedef logic        [31:0] ms_t;
  typedef logic        [7:0]  deg_t;

  // command modes
  localparam mode_t MODE_MOVE    = 3'd0;
  localparam mode_t MODE_TICK    = 3'd1;
  localparam mode_t MODE_ENABLE  = 3'd2;
  localparam mode_t MODE_DISABLE = 3'd3;
  localparam mode_t MODE_STOP    = 3'd4;

  // configuration registers
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] REG_SLEW_SPEED     = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MOVE_THRESHOLD = 1'd1;
  localparam logic [15:0] SLEW_SPEED_RST     = 16'd5760;
  localparam logic [7:0]  MOVE_THRESHOLD_RST = 8'd32;

  // angles in 1/64 degree
  localparam int TURN_UNITS  = 23040;
  localparam int RANGE_UNITS = 11520;
  localparam int DEG_SHIFT   = 6;

  // step = speed * elapsed / 1000, saturated at the servo range
  localparam int PROD_W     = 48;
  localparam int SMALL_W    = 24;
  localparam int RECIP_W    = 25;
  localparam int RECIP_SH   = 34;
  localparam int MS_PER_S   = 1000;
  // ceil(2^34 / 1000), exact for dividends below 2^24
  localparam logic [RECIP_W-1:0] RECIP_MS = 25'd17179870;
  // largest product whose quotient still fits the range
  localparam logic [PROD_W-1:0] SAT_PROD = 48'((RANGE_UNITS + 1) * MS_PER_S - 1);

endpackage

[rtl/ssl_cmd_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssl_cmd_if: command channel of the servo slew limiter
// Valid/ready channel carrying one command: mode, requested angle, time.
// ----------------------------------------------------------------------------
interface ssl_cmd_if import ssl_pkg::*; ();

  logic   valid;
  logic   ready;
  mode_t  mode;
  angle_t requested_angle;
  ms_t    now_ms;

  modport source (output valid, mode, requested_angle, now_ms, input ready);
  modport sink   (input valid, mode, requested_angle, now_ms, output ready);

endinterface

[rtl/ssl_res_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssl_res_if: result channel of the servo slew limiter
// Valid/ready channel carrying position and drive state after each command.
// ----------------------------------------------------------------------------
interface ssl_res_if import ssl_pkg::*; ();

  logic valid;
  logic ready;
  pos_t position;
  deg_t drive_degrees;
  logic drive_write;
  logic is_moving;
  logic is_enabled;

  modport source (output valid, position, drive_degrees, drive_write, is_moving,
                  is_enabled, input ready);
  modport sink   (input valid, position, drive_degrees, drive_write, is_moving,
                  is_enabled, output ready);

endinterface

[rtl/servo_slew_limiter.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// servo_slew_limiter: rate-limited servo position ramp
// Channels:
//   name  dir  handshake      payload
//   cmd   in   valid/ready    mode, requested_angle, now_ms
//   res   out  valid/ready    position, drive_degrees, drive_write,
//                             is_moving, is_enabled
//   cfg   in   cfg_we only    cfg_index, cfg_data
// One transaction per cycle sustained while res.ready is high; stages are
// input register, product register, result register. The servo state
// updates in the result stage, so consecutive commands do not wait on each other.
// Synchronous active-high rst clears state, flags and valids and loads the
// register defaults. A stalled result holds the stages behind it; cmd.ready
// drops only when all three stages are full and res.ready is low.
// ----------------------------------------------------------------------------
module servo_slew_limiter import ssl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  ssl_cmd_if.sink               cmd,
  ssl_res_if.source             res,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  // configuration
  logic [15:0] slew_speed;
  logic [7:0]  move_threshold;

  // servo state
  pos_t cur_pos;
  pos_t tgt_pos;
  logic moving;
  logic enabled;
  ms_t  last_ms;
  logic last_upd;

  // stage 1: input register
  logic   s1_valid;
  mode_t  s1_mode;
  angle_t s1_angle;
  ms_t    s1_now;

  // stage 2: products and folded angle
  logic              s2_valid;
  mode_t             s2_mode;
  pos_t              s2_fold;
  ms_t               s2_now;
  logic [PROD_W-1:0] s2_prod_a;
  logic [PROD_W-1:0] s2_prod_b;
  logic              s2_zero_a;
  logic              s2_zero_b;
  logic              s2_fwd;

  // result register
  logic out_valid;
  pos_t out_pos;
  logic out_write;
  logic out_moving;
  logic out_enabled;

  logic out_free;
  logic s2_adv;
  logic s1_adv;
  logic cmd_acc;

  assign out_free = !out_valid || res.ready;
  assign s2_adv   = s2_valid && out_free;
  assign s1_adv   = s1_valid && (!s2_valid || s2_adv);
  assign cmd.ready = !s1_valid || s1_adv;
  assign cmd_acc  = cmd.valid && cmd.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      slew_speed     <= SLEW_SPEED_RST;
      move_threshold <= MOVE_THRESHOLD_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SLEW_SPEED:     slew_speed     <= cfg_data;
        REG_MOVE_THRESHOLD: move_threshold <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // stage 1 -> 2: elapsed times, products, angle fold
  // --------------------------------------------------------------------------
  ms_t               elapsed_a;
  ms_t               elapsed_b;
  logic [PROD_W-1:0] prod_a;
  logic [PROD_W-1:0] prod_b;
  logic signed [16:0] ang_ext;
  logic signed [16:0] ang_wrap;
  pos_t              fold;

  // a: against the committed time stamp; b: against the command ahead,
  // used when that command moves the stamp to its own time
  assign elapsed_a = s1_now - last_ms;
  assign elapsed_b = s1_now - s2_now;
  assign prod_a    = PROD_W'(slew_speed) * PROD_W'(elapsed_a);
  assign prod_b    = PROD_W'(slew_speed) * PROD_W'(elapsed_b);

  always_comb begin
    ang_ext = {s1_angle[15], s1_angle};
    if (ang_ext[16]) begin
      ang_wrap = ang_ext + 17'(TURN_UNITS);
    end else if (ang_ext >= 17'(TURN_UNITS)) begin
      ang_wrap = ang_ext - 17'(TURN_UNITS);
    end else begin
      ang_wrap = ang_ext;
    end
    if (ang_wrap[16]) begin
      fold = '0;
    end else if (ang_wrap > 17'(RANGE_UNITS)) begin
      fold = pos_t'(RANGE_UNITS);
    end else begin
      fold = ang_wrap[13:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (cmd.ready) s1_valid <= cmd.valid;
      if (s1_adv || s2_adv) s2_valid <= s1_adv;
    end
    if (cmd_acc) begin
      s1_mode  <= cmd.mode;
      s1_angle <= cmd.requested_angle;
      s1_now   <= cmd.now_ms;
    end
    if (s1_adv) begin
      s2_mode   <= s1_mode;
      s2_fold   <= fold;
      s2_now    <= s1_now;
      s2_prod_a <= prod_a;
      s2_prod_b <= prod_b;
      s2_zero_a <= (elapsed_a == '0);
      s2_zero_b <= (elapsed_b == '0);
      s2_fwd    <= s2_adv;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2 -> result: step, state update
  // --------------------------------------------------------------------------
  logic                      use_b;
  logic [PROD_W-1:0]         prod;
  logic                      no_time;
  logic [SMALL_W+RECIP_W-1:0] quot_full;
  pos_t                      step;
  logic                      up;
  pos_t                      diff;
  pos_t                      err;
  pos_t                      cur_next;
  pos_t                      tgt_next;
  logic                      moving_next;
  logic                      enabled_next;
  ms_t                       last_ms_next;
  logic                      last_upd_next;
  logic                      write_next;

  assign use_b     = s2_fwd && last_upd;
  assign prod      = use_b ? s2_prod_b : s2_prod_a;
  assign no_time   = use_b ? s2_zero_b : s2_zero_a;
  assign quot_full = (SMALL_W + RECIP_W)'(prod[SMALL_W-1:0]) *
                     (SMALL_W + RECIP_W)'(RECIP_MS);
  assign step      = (prod > SAT_PROD) ? pos_t'(RANGE_UNITS)
                                       : quot_full[RECIP_SH +: 14];
  assign up        = tgt_pos > cur_pos;
  assign diff      = up ? tgt_pos - cur_pos : cur_pos - tgt_pos;
  assign err       = (s2_fold > cur_pos) ? s2_fold - cur_pos : cur_pos - s2_fold;

  always_comb begin
    cur_next      = cur_pos;
    tgt_next      = tgt_pos;
    moving_next   = moving;
    enabled_next  = enabled;
    last_ms_next  = last_ms;
    last_upd_next = 1'b0;
    write_next    = 1'b0;
    case (s2_mode)
      MODE_MOVE: begin
        tgt_next      = s2_fold;
        moving_next   = err > pos_t'(move_threshold);
        last_ms_next  = s2_now;
        last_upd_next = 1'b1;
      end
      MODE_TICK: begin
        if (enabled && moving && !no_time) begin
          if (diff <= step) begin
            cur_next    = tgt_pos;
            moving_next = 1'b0;
          end else if (up) begin
            cur_next = cur_pos + step;
          end else begin
            cur_next = cur_pos - step;
          end
          write_next    = 1'b1;
          last_ms_next  = s2_now;
          last_upd_next = 1'b1;
        end
      end
      MODE_ENABLE: begin
        enabled_next = 1'b1;
        write_next   = !moving;
      end
      MODE_DISABLE: begin
        enabled_next = 1'b0;
        moving_next  = 1'b0;
      end
      MODE_STOP: begin
        tgt_next    = cur_pos;
        moving_next = 1'b0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_pos   <= '0;
      tgt_pos   <= '0;
      moving    <= 1'b0;
      enabled   <= 1'b0;
      last_ms   <= '0;
      last_upd  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (out_free) out_valid <= s2_valid;
      if (s2_adv) begin
        cur_pos  <= cur_next;
        tgt_pos  <= tgt_next;
        moving   <= moving_next;
        enabled  <= enabled_next;
        last_ms  <= last_ms_next;
        last_upd <= last_upd_next;
      end
    end
    if (s2_adv) begin
      out_pos     <= cur_next;
      out_write   <= write_next;
      out_moving  <= moving_next && enabled_next;
      out_enabled <= enabled_next;
    end
  end

  assign res.valid         = out_valid;
  assign res.position      = out_pos;
  assign res.drive_degrees = deg_t'(out_pos >> DEG_SHIFT);
  assign res.drive_write   = out_write;
  assign res.is_moving     = out_moving;
  assign res.is_enabled    = out_enabled;

`ifndef SYNTH
  // a moving servo has somewhere to go
  a_moving_off_target: assert property (@(posedge clk) disable iff (rst)
    moving |-> (cur_pos != tgt_pos))
    else $error("moving flag set with position on target");

  // target and position stay inside the servo range
  a_state_in_range: assert property (@(posedge clk) disable iff (rst)
    (tgt_pos <= pos_t'(RANGE_UNITS)) && (cur_pos <= pos_t'(RANGE_UNITS)))
    else $error("servo state outside range");

  // a stalled result blocks the state update behind it
  a_stall_holds_state: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !res.ready) |=> $stable(cur_pos) && $stable(tgt_pos))
    else $error("state changed while result stalled");

  // a drive update reports the new position with the servo enabled
  a_write_enabled: assert property (@(posedge clk) disable iff (rst)
    (res.valid && res.drive_write) |-> res.is_enabled)
    else $error("drive update while disabled");
`endif

endmodule
